/* hdl/tvw_pkg.sv */
// ----------------------------------------------------------------------------
// tvw_pkg
// Shared widths, limits and state codes for the triangle vertex welder.
// ----------------------------------------------------------------------------
package tvw_pkg;

    // vertex table depth and derived widths
    localparam int MAX_VERTICES = 4096;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    // fixed field widths
    localparam int COORD_W = 32;
    localparam int VTX_W   = 3 * COORD_W;
    localparam int IDX_W   = 12;
    localparam int TOT_W   = 13;

    // triangle count stops here
    localparam logic [TOT_W-1:0] TRI_SAT = TOT_W'(4096);

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_APPEND = 5'b01000,
        ST_FINISH = 5'b10000
    } tvw_state_t;

endpackage

/* hdl/tvw_ram.sv */
// ----------------------------------------------------------------------------
// tvw_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tvw_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* hdl/triangle_vertex_welder.sv */
// ----------------------------------------------------------------------------
// triangle_vertex_welder
// Welds the vertices of a triangle stream into one shared vertex table.
// ----------------------------------------------------------------------------
// Each input beat is one triangle; each output beat gives its three vertex
// indices, the stored vertex and triangle counts and an overflow flag. A
// triangle that starts a mesh goes straight to indices 0, 1, 2. Any other
// triangle scans the stored table from index 0, one entry per cycle through
// the single read port of the vertex RAM, until all three vertices have
// matched or the stored entries run out; unmatched vertices are then written
// one per cycle through the write port. If they do not fit in the room left,
// nothing is written and the beat carries zero indices and the overflow flag.
// The scan reads at most the stored count of entries, up to 4096, and the
// result waits in the finish state until the output side is free. A new
// triangle can be taken the cycle after the previous one has reached the
// output register. No clearing pass is needed after reset.
module triangle_vertex_welder
    import tvw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // triangle input
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                first_of_mesh,
    input  logic signed [31:0]  a_x,
    input  logic signed [31:0]  a_y,
    input  logic signed [31:0]  a_z,
    input  logic signed [31:0]  b_x,
    input  logic signed [31:0]  b_y,
    input  logic signed [31:0]  b_z,
    input  logic signed [31:0]  c_x,
    input  logic signed [31:0]  c_y,
    input  logic signed [31:0]  c_z,
    // result output
    output logic                out_valid,
    input  logic                out_ready,
    output logic [IDX_W-1:0]    index_a,
    output logic [IDX_W-1:0]    index_b,
    output logic [IDX_W-1:0]    index_c,
    output logic [TOT_W-1:0]    vertex_total,
    output logic [TOT_W-1:0]    triangle_total,
    output logic                overflow
);

    // control state
    tvw_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   vcount_reg, vcount_next;
    logic [TOT_W-1:0]   tcount_reg, tcount_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic               pend_reg, pend_next;
    logic [1:0]         slot_reg, slot_next;
    logic               out_valid_reg, out_valid_next;

    // working payload
    logic [ADDR_W-1:0]  cmp_addr_reg, cmp_addr_next;
    logic [2:0]         hit_reg, hit_next;
    logic [ADDR_W-1:0]  idx_reg [3];
    logic [ADDR_W-1:0]  idx_next [3];
    logic [VTX_W-1:0]   vtx_reg [3];
    logic               ovf_reg, ovf_next;

    // output payload
    logic [IDX_W-1:0]   index_a_reg, index_b_reg, index_c_reg;
    logic [TOT_W-1:0]   vtot_reg, ttot_reg;
    logic               ovf_out_reg;

    // memory port
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [VTX_W-1:0]   ram_wdata;
    logic [VTX_W-1:0]   ram_rdata;

    logic               in_fire;
    logic               out_free;
    logic [1:0]         need;
    logic [CNT_W-1:0]   free_slots;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // vertex table
    tvw_ram #(
        .WIDTH (VTX_W),
        .DEPTH (MAX_VERTICES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // unmatched vertices and room left
    assign need = {1'b0, !hit_reg[0]} + {1'b0, !hit_reg[1]} + {1'b0, !hit_reg[2]};
    assign free_slots = CNT_W'(MAX_VERTICES) - vcount_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        vcount_next    = vcount_reg;
        tcount_next    = tcount_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg;
        cmp_addr_next  = cmp_addr_reg;
        hit_next       = hit_reg;
        idx_next       = idx_reg;
        ovf_next       = ovf_reg;
        ram_we         = 1'b0;
        ram_waddr      = vcount_reg[ADDR_W-1:0];
        ram_wdata      = vtx_reg[slot_reg];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    hit_next  = 3'b000;
                    ovf_next  = 1'b0;
                    ptr_next  = '0;
                    pend_next = 1'b0;
                    if (first_of_mesh)
                    begin
                        vcount_next = '0;
                        tcount_next = '0;
                        state_next  = ST_DECIDE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // compare the entry that came back from the table
                if (pend_reg)
                begin
                    for (int e = 0; e < 3; e++)
                    begin
                        if (ram_rdata == vtx_reg[e])
                        begin
                            hit_next[e] = 1'b1;
                            idx_next[e] = cmp_addr_reg;
                        end
                    end
                end
                if ((pend_reg && (&hit_next)) || (ptr_reg >= vcount_reg))
                begin
                    pend_next  = 1'b0;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    // read at ptr is issued this cycle
                    pend_next     = 1'b1;
                    cmp_addr_next = ptr_reg[ADDR_W-1:0];
                    ptr_next      = ptr_reg + CNT_W'(1);
                end
            end

            ST_DECIDE:
            begin
                slot_next = '0;
                if (CNT_W'(need) > free_slots)
                begin
                    ovf_next = 1'b1;
                    for (int e = 0; e < 3; e++)
                    begin
                        idx_next[e] = '0;
                    end
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_APPEND;
                end
            end

            ST_APPEND:
            begin
                // one unmatched vertex written per cycle
                if (!hit_reg[slot_reg])
                begin
                    ram_we             = 1'b1;
                    idx_next[slot_reg] = vcount_reg[ADDR_W-1:0];
                    vcount_next        = vcount_reg + CNT_W'(1);
                end
                if (slot_reg == 2'd2)
                begin
                    if (tcount_reg < TRI_SAT)
                    begin
                        tcount_next = tcount_reg + TOT_W'(1);
                    end
                    state_next = ST_FINISH;
                end
                else
                begin
                    slot_next = slot_reg + 2'd1;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vcount_reg    <= '0;
            tcount_reg    <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            tcount_reg    <= tcount_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working payload registers
    always_ff @(posedge clk)
    begin
        cmp_addr_reg <= cmp_addr_next;
        hit_reg      <= hit_next;
        idx_reg      <= idx_next;
        ovf_reg      <= ovf_next;
        if (in_fire)
        begin
            vtx_reg[0] <= {a_x, a_y, a_z};
            vtx_reg[1] <= {b_x, b_y, b_z};
            vtx_reg[2] <= {c_x, c_y, c_z};
        end
    end

    // output beat register
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && out_free)
        begin
            index_a_reg <= IDX_W'(idx_reg[0]);
            index_b_reg <= IDX_W'(idx_reg[1]);
            index_c_reg <= IDX_W'(idx_reg[2]);
            vtot_reg    <= TOT_W'(vcount_reg);
            ttot_reg    <= tcount_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign index_a        = index_a_reg;
    assign index_b        = index_b_reg;
    assign index_c        = index_c_reg;
    assign vertex_total   = vtot_reg;
    assign triangle_total = ttot_reg;
    assign overflow       = ovf_out_reg;

    // stored count never passes the table depth
    a_vcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond table depth");

    // table is written only while appending
    a_write_append: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_APPEND))
        else $error("table write outside append");

    // triangle count saturates
    a_tcount_sat: assert property (@(posedge clk) disable iff (!rst_n)
        tcount_reg <= TRI_SAT)
        else $error("triangle count past saturation");

    // an overflowed beat carries zero indices
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ovf_out_reg) |->
            (index_a_reg == '0 && index_b_reg == '0 && index_c_reg == '0))
        else $error("overflow beat with nonzero index");

    // an accepted triangle goes to scan or straight to the room check
    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_SCAN || state_reg == ST_DECIDE))
        else $error("bad state after accept");

    // no read is outstanding outside the scan
    a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_SCAN))
        else $error("read pending outside scan");

endmodule
